// ----- design/sfm_pkg.sv -----
// Shared types and constants for the streaming first-match substring search.
// Holds the request payload structs and the configuration register indexes.
// No dependencies.
`default_nettype none

package sfm_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_OUT_W = 16;
    localparam int NLEN_W    = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NDL_BYTES = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_NEEDLE_LOW    = 3'd0;
    localparam t_cfg_idx CFG_NEEDLE_HIGH   = 3'd1;
    localparam t_cfg_idx CFG_NEEDLE_LENGTH = 3'd2;
    localparam t_cfg_idx CFG_START_OFFSET  = 3'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              is_last;
    } t_in;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] match_position;
    } t_out;

endpackage

`default_nettype wire

// ----- design/substring_first_match.sv -----
// Streaming first-match substring search: one text byte per request; each result is registered in the output buffer.
// Throughput 1 byte per cycle while the output buffer has room; a row of MAX_NEEDLE window cells compares in parallel.
// The two-entry output buffer keeps input flowing while one result waits.
// Synchronous active-low reset clears config registers, position, match flag and buffer.
// Depends on sfm_pkg, sfm_cell, sfm_out_buf.
`default_nettype none

module substring_first_match #(
    parameter int MAX_NEEDLE = 16,
    parameter int MAX_TEXT   = 65536
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // text byte requests
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire sfm_pkg::t_in                 i_in_data,
    // result requests
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output sfm_pkg::t_out                     o_out_data,
    // configuration writes
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire sfm_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [sfm_pkg::CFG_W-1:0]    i_cfg_data
);
    import sfm_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int CMP_W = ((POS_W > POS_OUT_W) ? POS_W : POS_OUT_W) + 1;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0]     r_needle_low;
    logic [CFG_W-1:0]     r_needle_high;
    logic [NLEN_W-1:0]    r_needle_len;
    logic [POS_OUT_W-1:0] r_start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
            r_start       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NEEDLE_LOW:    r_needle_low  <= i_cfg_data;
                CFG_NEEDLE_HIGH:   r_needle_high <= i_cfg_data;
                CFG_NEEDLE_LENGTH: r_needle_len  <= i_cfg_data[NLEN_W-1:0];
                CFG_START_OFFSET:  r_start       <= i_cfg_data[POS_OUT_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // needle as a byte array, byte zero in the lowest lane
    logic [NDL_BYTES-1:0][BYTE_W-1:0] w_needle;
    assign w_needle = {r_needle_high, r_needle_low};

    // ---------------- input handshake and position ----------------
    logic w_accept;
    logic w_space;
    logic w_shift;
    logic w_in_range;
    logic [POS_W-1:0] r_pos, n_pos;
    logic r_done, n_done;

    assign o_in_ready = w_space;
    assign w_accept   = i_in_valid && w_space;
    // bytes past the text bound are not examined; only their last mark acts
    assign w_in_range = r_pos < POS_W'(MAX_TEXT);
    assign w_shift    = w_accept && w_in_range;

    // ---------------- window cell row ----------------
    // cell j holds the byte j places behind the newest; the needle's last byte
    // lines up with cell 0, so cell j checks needle byte (length - 1 - j)
    logic [MAX_NEEDLE:0][BYTE_W-1:0] w_chain;
    logic [MAX_NEEDLE-1:0]           w_cell_match;

    assign w_chain[0] = i_in_data.text_byte;

    for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
        logic [NLEN_W-1:0] w_idx;
        logic              w_active;

        assign w_idx    = r_needle_len - NLEN_W'(1) - NLEN_W'(j);
        assign w_active = NLEN_W'(j) < r_needle_len;

        sfm_cell u_cell (
            .i_clk         (i_clk),
            .i_shift       (w_shift),
            .i_byte        (w_chain[j]),
            .i_needle_byte (w_needle[w_idx[3:0]]),
            .i_active      (w_active),
            .o_byte        (w_chain[j+1]),
            .o_match       (w_cell_match[j])
        );
    end

    // ---------------- match decision ----------------
    logic [CMP_W-1:0] w_count;
    logic [CMP_W-1:0] w_need;
    logic [CMP_W-1:0] w_diff;
    logic             w_len_ok;
    logic             w_hit;
    logic             w_last;
    logic             w_push;
    t_out             w_result;

    assign w_count  = CMP_W'(r_pos) + CMP_W'(1);
    // the needle fits only when its end is at or past start + length
    assign w_need   = CMP_W'(r_needle_len) + CMP_W'(r_start);
    assign w_diff   = w_count - CMP_W'(r_needle_len);
    assign w_len_ok = r_needle_len <= NLEN_W'(MAX_NEEDLE);
    assign w_last   = i_in_data.is_last;

    always_comb begin
        w_hit = 1'b0;
        if (w_in_range && !r_done && w_len_ok && (w_count >= w_need)) begin
            // empty needle matches as soon as the count reaches the start offset
            w_hit = (r_needle_len == '0) || (&w_cell_match);
        end
    end

    always_comb begin
        w_result = '0;
        if (w_hit) begin
            w_result.found          = 1'b1;
            w_result.match_position = (r_needle_len == '0) ? r_start
                                                           : w_diff[POS_OUT_W-1:0];
        end
    end

    // report a hit, or not-found when the text ends without one
    assign w_push = w_accept && (w_hit || (w_last && !r_done));

    always_comb begin
        n_pos  = r_pos;
        n_done = r_done;
        if (w_accept) begin
            if (w_last) begin
                n_pos  = '0;
                n_done = 1'b0;
            end else begin
                if (w_in_range) begin
                    n_pos = r_pos + POS_W'(1);
                end
                if (w_hit) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_done <= n_done;
        end
    end

    // ---------------- result buffer ----------------
    sfm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- design/sfm_cell.sv -----
// One cell of the text window: holds one byte and compares the byte entering it.
// Depends on sfm_pkg.
`default_nettype none

module sfm_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_shift,
    input  wire logic [sfm_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [sfm_pkg::BYTE_W-1:0] i_needle_byte,
    input  wire logic                      i_active,
    output logic      [sfm_pkg::BYTE_W-1:0] o_byte,
    output logic                           o_match
);
    import sfm_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // compare the byte this cell takes on the shift; unused cells always agree
    assign o_match = !i_active || (i_byte == i_needle_byte);
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ----- design/sfm_out_buf.sv -----
// Two-entry output buffer (main register plus skid register) for result requests.
// Depends on sfm_pkg.
`default_nettype none

module sfm_out_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfm_pkg::t_out i_data,
    output logic               o_space,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sfm_pkg::t_out      o_data
);
    import sfm_pkg::*;

    logic r_main_valid, n_main_valid;
    logic r_skid_valid, n_skid_valid;
    t_out r_main, n_main;
    t_out r_skid, n_skid;
    logic w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || w_pop) begin
            // refill main from skid first, then from the new request
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for substring_first_match: text byte, result and register write channels.
// Checks every result against an in-bench search predictor, directed rows first, then random.
// Depends on sfm_pkg and substring_first_match.
`default_nettype none

module tb_top;
    import sfm_pkg::*;

    localparam int TEXT_LIMIT  = 65536;  // matches the MAX_TEXT default of u_dut
    localparam int HOLD_OFF    = 4;      // margin for the registered result plus the output buffer depth
    localparam int DRAIN_WAIT  = 8;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 112;
    localparam int PRINT_CAP   = 100;

    // How a directed row pins its own outcome, beside the predictor check.
    typedef enum logic [1:0] {PIN_NONE, PIN_RESULT, PIN_QUIET} pin_e;
    typedef enum logic {ROW_CFG, ROW_TEXT} row_e;

    typedef struct {
        row_e              kind;
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        logic [NLEN_W-1:0] len;
        logic [15:0]       start;
        t_in               item;
        pin_e              pin;
        t_out              want;
    } row_t;

    // Block ports; every input holds a known value from time zero.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in              i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_idx         i_cfg_index = CFG_NEEDLE_LOW;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // Outcome pinned by the directed row now on the text channel.
    pin_e cur_pin  = PIN_NONE;
    t_out cur_want = '0;

    bit calm        = 1'b0;  // no idling on either side while set
    int idle_cycles = 0;
    int mismatches  = 0;

    // Search predictor: its own copy of the registers and the per-text state.
    logic [BYTE_W-1:0] seen_bytes [NDL_BYTES];  // entry 0 is the newest byte
    int                seen_count   = 0;
    bit                hit_reported = 1'b0;
    logic [CFG_W-1:0]  ndl_lo    = '0;
    logic [CFG_W-1:0]  ndl_hi    = '0;
    logic [NLEN_W-1:0] ndl_len   = '0;
    logic [15:0]       ndl_start = '0;
    t_out              awaited_results [$];

    // Random text generator state.
    logic [BYTE_W-1:0] letters [3];
    logic [BYTE_W-1:0] ndl_plan [NDL_BYTES];
    int                plan_len;
    t_in               text_q [$];
    row_t              script [$];

    substring_first_match u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [BYTE_W-1:0] needle_at(input int k);
        if (k < 8) return ndl_lo[8*k +: 8];
        if (k < 16) return ndl_hi[8*(k-8) +: 8];
        return '0;
    endfunction

    task automatic forget_text();
        foreach (seen_bytes[i]) seen_bytes[i] = '0;
        seen_count   = 0;
        hit_reported = 1'b0;
    endtask

    // Advance the predictor by one text byte; made tells whether a result is due.
    task automatic search_byte(input t_in it, output bit made, output t_out res);
        bit hit;
        bit same;
        int at;
        int nlen;
        int first;
        int i;
        int k;
        hit   = 1'b0;
        at    = 0;
        made  = 1'b0;
        res   = '0;
        nlen  = int'(ndl_len);
        first = int'(ndl_start);
        // Bytes past the position bound are not examined; only is_last still acts.
        if (seen_count < TEXT_LIMIT) begin
            for (i = NDL_BYTES - 1; i > 0; i--) seen_bytes[i] = seen_bytes[i-1];
            seen_bytes[0] = it.text_byte;
            seen_count++;
            if (!hit_reported) begin
                if (nlen == 0) begin
                    // Empty needle: matches once the count reaches the start offset.
                    if (seen_count >= first) begin
                        hit = 1'b1;
                        at  = first;
                    end
                end else if (nlen <= NDL_BYTES && seen_count >= nlen
                             && seen_count - nlen >= first) begin
                    same = 1'b1;
                    for (k = 0; k < nlen; k++) begin
                        if (seen_bytes[nlen-1-k] != needle_at(k)) same = 1'b0;
                    end
                    if (same) begin
                        hit = 1'b1;
                        at  = seen_count - nlen;
                    end
                end
            end
        end
        if (hit) begin
            hit_reported       = 1'b1;
            made               = 1'b1;
            res.found          = 1'b1;
            res.match_position = at[15:0];
        end else if (it.is_last && !hit_reported) begin
            made = 1'b1;
        end
        if (it.is_last) forget_text();
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Watch all three channels at each edge: register writes, text requests, results.
    always @(posedge i_clk) begin : watch_ports
        bit   made;
        bit   moved;
        t_out res;
        t_out want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    CFG_NEEDLE_LOW:    ndl_lo    = i_cfg_data;
                    CFG_NEEDLE_HIGH:   ndl_hi    = i_cfg_data;
                    CFG_NEEDLE_LENGTH: ndl_len   = i_cfg_data[NLEN_W-1:0];
                    CFG_START_OFFSET:  ndl_start = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                search_byte(i_in_data, made, res);
                if (made) awaited_results.push_back(res);
                case (cur_pin)
                    PIN_RESULT: begin
                        if (!made || res !== cur_want)
                            report_mismatch("directed row: pinned result not predicted");
                    end
                    PIN_QUIET: begin
                        if (made) report_mismatch("directed row: result predicted, none pinned");
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result request with no result awaited");
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.found !== want.found)
                        report_mismatch($sformatf("found %0b, awaited %0b",
                                                  o_out_data.found, want.found));
                    if (o_out_data.match_position !== want.match_position)
                        report_mismatch($sformatf("match_position %0d, awaited %0d",
                                                  o_out_data.match_position,
                                                  want.match_position));
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // End the run when no request of any kind has moved for too long.
    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Result side: draw a stall per result, then hold ready until one is taken.
    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Offer one text byte after a random gap; return at the edge that takes it.
    task automatic push_byte(input t_in it, input pin_e pin, input t_out want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        cur_pin    <= pin;
        cur_want   <= want;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // Drop valid, hold until every awaited result is in, then let extra cycles pass.
    task automatic wait_results_done(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // Write all four registers while the block is idle; upper bits of the
    // narrow registers carry junk that the block must drop.
    task automatic program_search(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                  input logic [NLEN_W-1:0] len, input logic [15:0] start);
        logic [CFG_W-1:0] junk;
        wait_results_done(HOLD_OFF);
        write_reg(CFG_NEEDLE_LOW, lo);
        write_reg(CFG_NEEDLE_HIGH, hi);
        junk = {$urandom, $urandom};
        write_reg(CFG_NEEDLE_LENGTH, {junk[CFG_W-1:NLEN_W], len});
        junk = {$urandom, $urandom};
        write_reg(CFG_START_OFFSET, {junk[CFG_W-1:16], start});
        // Indexes past the register list must be ignored.
        if ($urandom_range(0, 1) == 1)
            write_reg(t_cfg_idx'(int'(CFG_START_OFFSET) + $urandom_range(1, 4)),
                      {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic row_t cfg_row(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                     input logic [NLEN_W-1:0] len, input logic [15:0] start);
        row_t r;
        r.kind  = ROW_CFG;
        r.lo    = lo;
        r.hi    = hi;
        r.len   = len;
        r.start = start;
        r.item  = '0;
        r.pin   = PIN_NONE;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t text_row(input logic [BYTE_W-1:0] b, input logic last,
                                      input pin_e pin, input logic found,
                                      input logic [15:0] pos);
        row_t r;
        r.kind                = ROW_TEXT;
        r.lo                  = '0;
        r.hi                  = '0;
        r.len                 = '0;
        r.start               = '0;
        r.item.text_byte      = b;
        r.item.is_last        = last;
        r.pin                 = pin;
        r.want.found          = found;
        r.want.match_position = pos;
        return r;
    endfunction

    // Queue one random text: mostly letters of the phase alphabet, and, when the needle
    // fits, in half the texts a copy of the needle dropped in at a random place.
    task automatic refill_text();
        logic [BYTE_W-1:0] body [$];
        t_in               it;
        int                n;
        int                at;
        int                i;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 40);
        for (i = 0; i < n; i++)
            body.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                        : letters[$urandom_range(0, 2)]);
        if (plan_len >= 1 && plan_len <= NDL_BYTES && n >= plan_len
            && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, n - plan_len);
            for (i = 0; i < plan_len; i++) body[at+i] = ndl_plan[i];
        end
        for (i = 0; i < n; i++) begin
            it.text_byte = body[i];
            it.is_last   = (i == n - 1);
            text_q.push_back(it);
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        logic [15:0]       start;
        int                p;
        int                n;
        int                r;
        int                k;

        forget_text();

        // Directed rows. Pinned outcomes are the ones readable at a glance.
        // After reset: empty needle at offset zero matches on the first byte.
        script.push_back(text_row(8'h00, 1'b0, PIN_RESULT, 1'b1, 16'd0));
        // Already matched: the final byte only clears the text.
        script.push_back(text_row(8'hFF, 1'b1, PIN_QUIET, 1'b0, 16'd0));
        // Match on the final byte: found, and no not-found after it.
        script.push_back(text_row(8'h5A, 1'b1, PIN_RESULT, 1'b1, 16'd0));
        // One-byte needle of all ones.
        script.push_back(cfg_row(64'h0000_0000_0000_00FF, '0, 5'd1, 16'd0));
        script.push_back(text_row(8'h00, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'hFF, 1'b1, PIN_RESULT, 1'b1, 16'd1));
        // Needle FF 00 from offset 1: the hit at 0 is skipped, the one at 2 counts.
        script.push_back(cfg_row(64'h0000_0000_0000_00FF, '1, 5'd2, 16'd1));
        script.push_back(text_row(8'hFF, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'h00, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'hFF, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'h00, 1'b1, PIN_RESULT, 1'b1, 16'd2));
        // Needle longer than the window never matches.
        script.push_back(cfg_row('1, '1, 5'd31, 16'd0));
        script.push_back(text_row(8'hFF, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'hFF, 1'b1, PIN_RESULT, 1'b0, 16'd0));
        // Start offset beyond the text.
        script.push_back(cfg_row('0, '0, 5'd0, 16'hFFFF));
        script.push_back(text_row(8'h11, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'h22, 1'b1, PIN_RESULT, 1'b0, 16'd0));
        // Empty needle waits for the count to reach the offset.
        script.push_back(cfg_row('0, '0, 5'd0, 16'd2));
        script.push_back(text_row(8'h01, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'h02, 1'b0, PIN_RESULT, 1'b1, 16'd2));
        script.push_back(text_row(8'h03, 1'b1, PIN_QUIET, 1'b0, 16'd0));
        // Needle swapped mid-text: a position already passed is not looked at again.
        script.push_back(cfg_row(64'h41, '0, 5'd1, 16'd0));
        script.push_back(text_row(8'h20, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(cfg_row(64'h20, '0, 5'd1, 16'd0));
        script.push_back(text_row(8'h41, 1'b0, PIN_QUIET, 1'b0, 16'd0));
        script.push_back(text_row(8'h20, 1'b1, PIN_RESULT, 1'b1, 16'd2));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG)
                program_search(script[i].lo, script[i].hi, script[i].len, script[i].start);
            else
                push_byte(script[i].item, script[i].pin, script[i].want);
        end

        // Random phases. Each phase picks a needle and offset; a text left open
        // at the end of a phase carries on under the next setting.
        for (p = 0; p < PHASES; p++) begin
            calm = ($urandom_range(0, 3) == 0);
            foreach (letters[i]) letters[i] = 8'($urandom);
            case (p)
                0:       plan_len = NDL_BYTES;
                1:       plan_len = 0;
                2:       plan_len = 31;
                3:       plan_len = 1;
                4:       plan_len = $urandom_range(17, 30);
                default: plan_len = $urandom_range(1, NDL_BYTES);
            endcase
            foreach (ndl_plan[i])
                ndl_plan[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                          : letters[$urandom_range(0, 2)];
            for (k = 0; k < 8; k++) begin
                lo[8*k +: 8] = ndl_plan[k];
                hi[8*k +: 8] = ndl_plan[k+8];
            end
            r = $urandom_range(0, 9);
            if (p == 5)     start = 16'hFFFF;
            else if (r < 6) start = 16'($urandom_range(0, 3));
            else if (r < 9) start = 16'($urandom_range(0, 40));
            else            start = 16'($urandom_range(0, 65535));
            program_search(lo, hi, plan_len[NLEN_W-1:0], start);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (text_q.size() == 0) refill_text();
                // Now and then hold the sender until the result side is empty.
                if ($urandom_range(0, 63) == 0) wait_results_done(0);
                push_byte(text_q.pop_front(), PIN_NONE, '0);
            end
        end
        // Close the open text so its final result is due before the end.
        while (text_q.size() != 0) push_byte(text_q.pop_front(), PIN_NONE, '0);

        wait_results_done(DRAIN_WAIT);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/sfm_pkg.sv
design/sfm_cell.sv
design/sfm_out_buf.sv
design/substring_first_match.sv
test/tb_top.sv
